// ----- sv/assert_macros.svh -----
// Assertion macros of the nitrate estimator, used by regional_nitrate_estimator.
// Both macros sample on clk; the first one is masked while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- sv/rne_pkg.sv -----
`timescale 1ns / 1ps
// Types, region thresholds, polynomial coefficients and scaling constants
// of the regional nitrate estimator. No dependencies.
package rne_pkg;

  localparam int ACC_W = 56;

  typedef enum logic [2:0] {
    REG_DEFAULT,
    REG_EQUATORIAL,
    REG_GYRE,
    REG_POLAR,
    REG_ARABIAN
  } rne_region_t;

  typedef struct packed {
    logic        valid;
    logic        ok;
    rne_region_t region;
  } rne_tag_t;

  // a6 = A * 1e6, b3 = B * 1000, d3 = D * 1000; all scaled by 1e5
  typedef struct packed {
    logic signed [46:0] a6;
    logic signed [32:0] b3;
    logic signed [19:0] c;
    logic signed [29:0] d3;
    logic signed [15:0] e;
  } rne_coef_t;

  localparam logic signed [17:0] LAT_EQ_LO  = -18'sd18333;
  localparam logic signed [17:0] LAT_HI     = 18'sd30000;
  localparam logic signed [17:0] LAT_AR_LO  = 18'sd5000;
  localparam logic signed [16:0] SST_EQ     = 17'sd20000;
  localparam logic signed [16:0] SST_GYRE   = 17'sd28000;
  localparam logic signed [16:0] SST_POLAR  = 17'sd2000;
  localparam logic signed [20:0] CHL_EQ_LO  = 21'sd240;
  localparam logic signed [20:0] CHL_EQ_HI  = 21'sd10000;
  localparam logic signed [20:0] CHL_GY_LO  = 21'sd300;
  localparam logic signed [20:0] CHL_GY_HI  = 21'sd2000;
  localparam logic signed [20:0] CHL_PO_LO  = 21'sd100;
  localparam logic signed [20:0] CHL_PO_HI  = 21'sd2200;
  localparam logic signed [18:0] LON_AR_LO  = 19'sd45000;
  localparam logic signed [18:0] LON_AR_HI  = 19'sd86666;

  // nitrate = floor((acc + 5e7) / 1e8) = floor(((acc + 5e7) >> 8) / 390625)
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 56'sd50000000;
  localparam logic signed [ACC_W-1:0] SAT_LEVEL  = 56'sd3999950000000;
  localparam logic [31:0]             RECIP      = 32'd2882303761;
  localparam logic [18:0]             DIVISOR    = 19'd390625;
  localparam logic [15:0]             NITRATE_MAX = 16'd40000;

  function automatic rne_coef_t coef_of(input rne_region_t r);
    rne_coef_t k;
    unique case (r)
      REG_EQUATORIAL: k = '{a6: 47'sd34541000000000, b3: -33'sd2340000000,
                            c: 20'sd40000, d3: 30'sd1200000, e: -16'sd48};
      REG_GYRE:       k = '{a6: 47'sd9012000000000, b3: -33'sd602000000,
                            c: 20'sd9000, d3: -30'sd5000000, e: 16'sd0};
      REG_POLAR:      k = '{a6: 47'sd1298000000000, b3: -33'sd1361000000,
                            c: -20'sd416000, d3: -30'sd497000000, e: 16'sd26700};
      REG_ARABIAN:    k = '{a6: 47'sd11914000000000, b3: -33'sd838000000,
                            c: 20'sd15000, d3: -30'sd20000000, e: 16'sd0};
      default:        k = '{a6: 47'sd2568000000000, b3: -33'sd197000000,
                            c: 20'sd4000, d3: -30'sd163000000, e: 16'sd1200};
    endcase
    return k;
  endfunction

endpackage

// ----- sv/rne_scale.sv -----
`timescale 1ns / 1ps
// Rounding, divide-by-1e8 and clamp stages of the nitrate estimator.
// Depends on rne_pkg.
module rne_scale (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic signed [rne_pkg::ACC_W-1:0] acc,
  input  rne_pkg::rne_tag_t               tag_in,
  output logic [15:0]                     nitrate,
  output rne_pkg::rne_tag_t               tag_out
);
  import rne_pkg::*;

  rne_tag_t tag5, tag6, tag7;

  logic                  nonpos5, nonpos6, nonpos7;
  logic                  sat5, sat6, sat7;
  logic [33:0]           y5, y6, y7;
  logic [65:0]           prod6;
  logic [15:0]           q07;
  logic [34:0]           qm7;
  logic signed [ACC_W-1:0] rounded;
  logic [34:0]           rem;
  logic [15:0]           quot;

  assign rounded = acc + ROUND_HALF;
  assign rem     = {1'b0, y7} - qm7;
  assign quot    = (rem >= {16'd0, DIVISOR}) ? q07 + 16'd1 : q07;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag5    <= '0;
      tag6    <= '0;
      tag7    <= '0;
      tag_out <= '0;
    end else if (en) begin
      tag5    <= tag_in;
      tag6    <= tag5;
      tag7    <= tag6;
      tag_out <= tag7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nonpos5 <= acc[ACC_W-1] || (acc == '0);
      sat5    <= acc >= SAT_LEVEL;
      y5      <= rounded[41:8];

      prod6   <= y5 * RECIP;
      y6      <= y5;
      nonpos6 <= nonpos5;
      sat6    <= sat5;

      q07     <= prod6[65:50];
      qm7     <= prod6[65:50] * DIVISOR;
      y7      <= y6;
      nonpos7 <= nonpos6;
      sat7    <= sat6;

      if (!tag7.ok || nonpos7) begin
        nitrate <= 16'd0;
      end else if (sat7) begin
        nitrate <= NITRATE_MAX;
      end else begin
        nitrate <= quot;
      end
    end
  end

endmodule

// ----- sv/regional_nitrate_estimator.sv -----
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid / in_stall  chl_milli, chl_valid, sst_milli, lat_milli, lon_milli
// out      out_valid / out_stall nitrate_milli, result_valid, region_used
//
// One item per cycle unless a stalled output holds the pipeline; items leave in order.
// The pipeline moves as a whole: a stalled output freezes every stage and
// raises in_stall in the same cycle. Reset clears all valid bits.
// Depends on rne_pkg, rne_scale and assert_macros.svh.
`include "assert_macros.svh"
module regional_nitrate_estimator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [20:0] chl_milli,
  input  logic               chl_valid,
  input  logic signed [16:0] sst_milli,
  input  logic signed [17:0] lat_milli,
  input  logic signed [18:0] lon_milli,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        nitrate_milli,
  output logic               result_valid,
  output logic [2:0]         region_used
);
  import rne_pkg::*;

  logic        en;
  logic        chl_ok;
  logic        in_eq, in_gyre, in_polar, in_arab;
  rne_region_t region;

  rne_tag_t tag1, tag2, tag3, tag4, out_tag;

  logic signed [16:0] s1;
  logic signed [20:0] c1;
  logic signed [33:0] sq1;
  logic signed [41:0] cc1;

  rne_coef_t          k;
  logic signed [49:0] pb;
  logic signed [53:0] pc;
  logic signed [50:0] pd;
  logic signed [57:0] pe;

  logic signed [ACC_W-1:0] pa2, pb2, pc2, pd2, pe2;
  logic signed [ACC_W-1:0] t1, t2, t3;
  logic signed [ACC_W-1:0] acc4;

  assign en       = !(out_tag.valid && out_stall);
  assign in_stall = !en;

  assign chl_ok = chl_valid && !chl_milli[20];

  assign in_eq = (lat_milli <= LAT_HI) && (lat_milli >= LAT_EQ_LO) &&
                 (sst_milli > SST_EQ) && (chl_milli > CHL_EQ_LO) &&
                 (chl_milli < CHL_EQ_HI);
  assign in_gyre = (sst_milli > SST_GYRE) && (chl_milli >= CHL_GY_LO) &&
                   (chl_milli <= CHL_GY_HI);
  assign in_polar = (sst_milli < SST_POLAR) && (chl_milli <= CHL_PO_HI) &&
                    (chl_milli >= CHL_PO_LO);
  assign in_arab = (lon_milli >= LON_AR_LO) && (lon_milli <= LON_AR_HI) &&
                   (lat_milli <= LAT_HI) && (lat_milli >= LAT_AR_LO);

  always_comb begin
    priority if (!chl_ok) region = REG_DEFAULT;
    else if (in_arab)     region = REG_ARABIAN;
    else if (in_polar)    region = REG_POLAR;
    else if (in_gyre)     region = REG_GYRE;
    else if (in_eq)       region = REG_EQUATORIAL;
    else                  region = REG_DEFAULT;
  end

  assign k  = coef_of(tag1.region);
  assign pb = k.b3 * s1;
  assign pc = k.c * sq1;
  assign pd = k.d3 * c1;
  assign pe = k.e * cc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
      tag4 <= '0;
    end else if (en) begin
      tag1 <= '{valid: in_valid, ok: chl_ok, region: region};
      tag2 <= tag1;
      tag3 <= tag2;
      tag4 <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1   <= sst_milli;
      c1   <= chl_milli;
      sq1  <= sst_milli * sst_milli;
      cc1  <= chl_milli * chl_milli;

      pa2  <= {{(ACC_W-47){k.a6[46]}}, k.a6};
      pb2  <= {{(ACC_W-50){pb[49]}}, pb};
      pc2  <= {{(ACC_W-54){pc[53]}}, pc};
      pd2  <= {{(ACC_W-51){pd[50]}}, pd};
      pe2  <= pe[ACC_W-1:0];

      t1   <= pa2 + pb2;
      t2   <= pc2 + pd2;
      t3   <= pe2;

      acc4 <= t1 + t2 + t3;
    end
  end

  rne_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .acc     (acc4),
    .tag_in  (tag4),
    .nitrate (nitrate_milli),
    .tag_out (out_tag)
  );

  assign out_valid    = out_tag.valid;
  assign result_valid = out_tag.ok;
  assign region_used  = out_tag.region;

  `ASSERT_CLK(a_invalid_zero,
              out_valid && !result_valid |-> nitrate_milli == 16'd0 && region_used == REG_DEFAULT,
              "invalid item carries nonzero data")
  `ASSERT_CLK(a_nitrate_max, out_valid |-> nitrate_milli <= NITRATE_MAX, "nitrate above clamp")
  `ASSERT_RST(a_reset_empty, rst |=> !out_valid, "item present after reset")

endmodule
